// ----- sv/hsvp_pkg.sv -----
// hsvp_pkg: shared constants and types for the HSV color-plane generator.
// Used by hsvp_div and hsv_plane_to_rgb; depends on nothing.
package hsvp_pkg;

	// plane geometry and color constants
	localparam int SIDE     = 470;
	localparam int CH_MAX   = 255;
	localparam int DEG_SECT = 60;
	localparam int HUE_FULL = 360;

	// fixed field widths
	localparam int ROW_W  = 9;
	localparam int HUE_W  = 9;
	localparam int CH_W   = 8;
	localparam int IDX_W  = 18;
	localparam int FR_W   = 6;

	// clamped row/column width
	localparam int R_W = $clog2(SIDE + 1);

	// every channel is floor(255*r*K / (60*SIDE^2)) with K = 60*SIDE - c*m
	localparam int KMAX = DEG_SECT * SIDE;
	localparam int K_W  = $clog2(KMAX + 1);
	localparam int A_W  = $clog2(CH_MAX * SIDE + 1);

	localparam longint unsigned NUM_MAX = longint'(CH_MAX) * longint'(SIDE) * longint'(KMAX);
	localparam int NUM_W = $clog2(NUM_MAX + 1);

	// common denominator and its scaled reciprocal (estimate is low by at most one)
	localparam longint unsigned D60    = longint'(DEG_SECT) * longint'(SIDE) * longint'(SIDE);
	localparam longint unsigned RECIP  = (longint'(1) << NUM_W) / D60;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W  = NUM_W + RECIP_W;

	// numerator word handed to the divider lanes
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [CH_W-1:0]  chan_t;

endpackage

// ----- sv/hsvp_div.sv -----
// hsvp_div: divide one channel numerator by 60*SIDE^2 with a reciprocal
// multiply and a single correction step. Depends on hsvp_pkg.
module hsvp_div (
	input  logic            clk,
	input  logic            en,
	input  hsvp_pkg::num_t  num,
	output hsvp_pkg::chan_t quot
);

	logic [hsvp_pkg::PROD_W-1:0] prod;
	hsvp_pkg::num_t              num_s3;
	hsvp_pkg::chan_t             est_s3;
	hsvp_pkg::num_t              rem;

	// reciprocal estimate: floor(num * RECIP / 2^NUM_W), low by at most one
	assign prod = hsvp_pkg::PROD_W'(num) * hsvp_pkg::PROD_W'(hsvp_pkg::RECIP);

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= num;
			est_s3 <= prod[hsvp_pkg::NUM_W +: hsvp_pkg::CH_W];
		end
	end

	// remainder check bumps the estimate when it fell one short
	assign rem  = num_s3 - hsvp_pkg::NUM_W'(hsvp_pkg::NUM_W'(est_s3) *
		hsvp_pkg::NUM_W'(hsvp_pkg::D60));
	assign quot = (rem >= hsvp_pkg::NUM_W'(hsvp_pkg::D60)) ? est_s3 + 1'b1 : est_s3;

endmodule

// ----- sv/hsv_plane_to_rgb.sv -----
// hsv_plane_to_rgb: top level of the HSV color-plane generator.
// Depends on hsvp_pkg and hsvp_div.
//
// Takes one pixel word (row, col) per clock and returns one RGB word per
// clock while the output is not stalled. Stage 1 clamps the coordinates
// and forms the small hue-fraction products, stage 2 holds the four wide
// channel numerators, stage 3 the reciprocal-multiply quotient estimates,
// and stage 4 the corrected channels after sector selection. Each stage
// advances on its own, so a stalled output fills bubbles before input stops.
// The user must write hue through hue_we/hue only while the block is idle
// (not enforced); it is reduced modulo 360 and split at write time into
// sector and fraction. No start-up sweep: ready right after reset.
module hsv_plane_to_rgb (
	input  logic                        clk,
	input  logic                        arst_n,
	// hue register
	input  logic                        hue_we,
	input  logic [hsvp_pkg::HUE_W-1:0]  hue,
	// pixel input
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hsvp_pkg::ROW_W-1:0]  row,
	input  logic [hsvp_pkg::ROW_W-1:0]  col,
	// color output
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [hsvp_pkg::CH_W-1:0]   red,
	output logic [hsvp_pkg::CH_W-1:0]   green,
	output logic [hsvp_pkg::CH_W-1:0]   blue,
	output logic [hsvp_pkg::IDX_W-1:0]  pixel_index
);

	typedef enum logic [2:0] {
		SECT_RY, SECT_YG, SECT_GC, SECT_CB, SECT_BM, SECT_MR
	} sector_t;

	sector_t                     sector_q, sector_d;
	logic [hsvp_pkg::FR_W-1:0]   fr_q, frc_q, fr_d;
	logic [hsvp_pkg::HUE_W-1:0]  h_mod;

	logic en1, en2, en3, en4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic [hsvp_pkg::R_W-1:0]   r_c, c_c;
	logic [hsvp_pkg::A_W-1:0]   a_c, a_s1;
	logic [hsvp_pkg::K_W-1:0]   kp_s1, kq_s1, kt_s1;
	logic [hsvp_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_s3;

	hsvp_pkg::num_t  nv_s2, np_s2, nq_s2, nt_s2;
	hsvp_pkg::chan_t qv, qp, qq, qt;

	// hue decode: modulo 360, then sector and fraction
	always_comb begin
		h_mod = (hue >= hsvp_pkg::HUE_W'(hsvp_pkg::HUE_FULL)) ?
			hue - hsvp_pkg::HUE_W'(hsvp_pkg::HUE_FULL) : hue;
		if (h_mod < hsvp_pkg::HUE_W'(hsvp_pkg::DEG_SECT)) begin
			sector_d = SECT_RY;
			fr_d     = hsvp_pkg::FR_W'(h_mod);
		end else if (h_mod < hsvp_pkg::HUE_W'(2 * hsvp_pkg::DEG_SECT)) begin
			sector_d = SECT_YG;
			fr_d     = hsvp_pkg::FR_W'(h_mod - hsvp_pkg::HUE_W'(hsvp_pkg::DEG_SECT));
		end else if (h_mod < hsvp_pkg::HUE_W'(3 * hsvp_pkg::DEG_SECT)) begin
			sector_d = SECT_GC;
			fr_d     = hsvp_pkg::FR_W'(h_mod - hsvp_pkg::HUE_W'(2 * hsvp_pkg::DEG_SECT));
		end else if (h_mod < hsvp_pkg::HUE_W'(4 * hsvp_pkg::DEG_SECT)) begin
			sector_d = SECT_CB;
			fr_d     = hsvp_pkg::FR_W'(h_mod - hsvp_pkg::HUE_W'(3 * hsvp_pkg::DEG_SECT));
		end else if (h_mod < hsvp_pkg::HUE_W'(5 * hsvp_pkg::DEG_SECT)) begin
			sector_d = SECT_BM;
			fr_d     = hsvp_pkg::FR_W'(h_mod - hsvp_pkg::HUE_W'(4 * hsvp_pkg::DEG_SECT));
		end else begin
			sector_d = SECT_MR;
			fr_d     = hsvp_pkg::FR_W'(h_mod - hsvp_pkg::HUE_W'(5 * hsvp_pkg::DEG_SECT));
		end
	end

	// hue register, kept in decoded form
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_q <= SECT_RY;
			fr_q     <= '0;
			frc_q    <= hsvp_pkg::FR_W'(hsvp_pkg::DEG_SECT);
		end else if (hue_we) begin
			sector_q <= sector_d;
			fr_q     <= fr_d;
			frc_q    <= hsvp_pkg::FR_W'(hsvp_pkg::DEG_SECT) - fr_d;
		end
	end

	// per-stage advance: a stage loads when empty or when its word moves on
	assign en4      = !valid_s4 || out_ready;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: clamp to the plane, 255*r, and K terms for p, q, t
	assign r_c = (int'(row) > hsvp_pkg::SIDE) ? hsvp_pkg::R_W'(hsvp_pkg::SIDE) :
		hsvp_pkg::R_W'(row);
	assign c_c = (int'(col) > hsvp_pkg::SIDE) ? hsvp_pkg::R_W'(hsvp_pkg::SIDE) :
		hsvp_pkg::R_W'(col);
	assign a_c = hsvp_pkg::A_W'(hsvp_pkg::A_W'(r_c) * hsvp_pkg::A_W'(hsvp_pkg::CH_MAX));

	always_ff @(posedge clk) begin
		if (en1) begin
			a_s1   <= a_c;
			kp_s1  <= hsvp_pkg::K_W'(hsvp_pkg::KMAX) -
				hsvp_pkg::K_W'(hsvp_pkg::K_W'(c_c) * hsvp_pkg::K_W'(hsvp_pkg::DEG_SECT));
			kq_s1  <= hsvp_pkg::K_W'(hsvp_pkg::KMAX) -
				hsvp_pkg::K_W'(hsvp_pkg::K_W'(c_c) * hsvp_pkg::K_W'(fr_q));
			kt_s1  <= hsvp_pkg::K_W'(hsvp_pkg::KMAX) -
				hsvp_pkg::K_W'(hsvp_pkg::K_W'(c_c) * hsvp_pkg::K_W'(frc_q));
			idx_s1 <= hsvp_pkg::IDX_W'(hsvp_pkg::IDX_W'(row) *
				hsvp_pkg::IDX_W'(hsvp_pkg::SIDE) + hsvp_pkg::IDX_W'(col));
		end
	end

	// stage 2: wide numerators 255*r*K
	always_ff @(posedge clk) begin
		if (en2) begin
			nv_s2  <= hsvp_pkg::NUM_W'(hsvp_pkg::NUM_W'(a_s1) *
				hsvp_pkg::NUM_W'(hsvp_pkg::KMAX));
			np_s2  <= hsvp_pkg::NUM_W'(hsvp_pkg::NUM_W'(a_s1) * hsvp_pkg::NUM_W'(kp_s1));
			nq_s2  <= hsvp_pkg::NUM_W'(hsvp_pkg::NUM_W'(a_s1) * hsvp_pkg::NUM_W'(kq_s1));
			nt_s2  <= hsvp_pkg::NUM_W'(hsvp_pkg::NUM_W'(a_s1) * hsvp_pkg::NUM_W'(kt_s1));
			idx_s2 <= idx_s1;
		end
	end

	// stage 3: one divider lane per channel term
	hsvp_div u_div_v (.clk(clk), .en(en3), .num(nv_s2), .quot(qv));
	hsvp_div u_div_p (.clk(clk), .en(en3), .num(np_s2), .quot(qp));
	hsvp_div u_div_q (.clk(clk), .en(en3), .num(nq_s2), .quot(qq));
	hsvp_div u_div_t (.clk(clk), .en(en3), .num(nt_s2), .quot(qt));

	always_ff @(posedge clk) begin
		if (en3) idx_s3 <= idx_s2;
	end

	// stage 4: sector select into the output register
	always_ff @(posedge clk) begin
		if (en4) begin
			pixel_index <= idx_s3;
			case (sector_q)
				SECT_RY: begin red <= qv; green <= qt; blue <= qp; end
				SECT_YG: begin red <= qq; green <= qv; blue <= qp; end
				SECT_GC: begin red <= qp; green <= qv; blue <= qt; end
				SECT_CB: begin red <= qp; green <= qq; blue <= qv; end
				SECT_BM: begin red <= qt; green <= qp; blue <= qv; end
				default: begin red <= qv; green <= qp; blue <= qq; end
			endcase
		end
	end

	assign out_valid = valid_s4;

endmodule
